// ----- src/raster_op_pixel_unit_16bpp_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the raster-operation pixel unit
// Wrap concurrent assertions so that every checker reports the same way.
// ----------------------------------------------------------------------------
`ifndef RASTER_OP_PIXEL_UNIT_16BPP_ASSERT_SVH
`define RASTER_OP_PIXEL_UNIT_16BPP_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define ROP16_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rop16 assertion failed");

// Next-cycle implication, off while reset is high.
`define ROP16_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rop16 assertion failed");

// Next-cycle implication that also holds across reset.
`define ROP16_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rop16 assertion failed");

`endif

// ----- src/rop16_pkg.sv -----
// ----------------------------------------------------------------------------
// rop16_pkg
// Types, operation codes and register indexes of the raster-operation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rop16_pkg;

   localparam int OP_W      = 6;
   localparam int PIX_W     = 16;
   localparam int COLOR_W   = 24;
   localparam int CSR_IDX_W = 3;
   localparam int BYTE_BITS = 8;

   typedef logic [OP_W-1:0]      op_type;
   typedef logic [PIX_W-1:0]     pix16_type;
   typedef logic [COLOR_W-1:0]   color_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam pix16_type PIX_MASK = 16'hFFFF;

   // ROP3 set
   localparam op_type OP_BLACKNESS   = 6'd0;
   localparam op_type OP_WHITENESS   = 6'd1;
   localparam op_type OP_SRCCOPY     = 6'd2;
   localparam op_type OP_NOTSRCCOPY  = 6'd3;
   localparam op_type OP_DSTINVERT   = 6'd4;
   localparam op_type OP_SRCERASE    = 6'd5;
   localparam op_type OP_NOTSRCERASE = 6'd6;
   localparam op_type OP_SRCINVERT   = 6'd7;
   localparam op_type OP_SRCAND      = 6'd8;
   localparam op_type OP_SRCPAINT    = 6'd9;
   localparam op_type OP_DSPDXAX     = 6'd10;
   localparam op_type OP_SPNA        = 6'd11;
   localparam op_type OP_PDXN        = 6'd12;
   localparam op_type OP_DSNA        = 6'd13;
   localparam op_type OP_MERGECOPY   = 6'd14;
   localparam op_type OP_MERGEPAINT  = 6'd15;
   localparam op_type OP_PATCOPY     = 6'd16;
   localparam op_type OP_PATINVERT   = 6'd17;
   localparam op_type OP_PATPAINT    = 6'd18;
   // ROP2 pen modes
   localparam op_type OP_R2_BLACK       = 6'd19;
   localparam op_type OP_R2_NOTMERGEPEN = 6'd20;
   localparam op_type OP_R2_MASKNOTPEN  = 6'd21;
   localparam op_type OP_R2_NOTCOPYPEN  = 6'd22;
   localparam op_type OP_R2_MASKPENNOT  = 6'd23;
   localparam op_type OP_R2_NOT         = 6'd24;
   localparam op_type OP_R2_XORPEN      = 6'd25;
   localparam op_type OP_R2_NOTMASKPEN  = 6'd26;
   localparam op_type OP_R2_MASKPEN     = 6'd27;
   localparam op_type OP_R2_NOTXORPEN   = 6'd28;
   localparam op_type OP_R2_NOP         = 6'd29;
   localparam op_type OP_R2_MERGENOTPEN = 6'd30;
   localparam op_type OP_R2_COPYPEN     = 6'd31;
   localparam op_type OP_R2_MERGEPENNOT = 6'd32;
   localparam op_type OP_R2_MERGEPEN    = 6'd33;
   localparam op_type OP_R2_WHITE       = 6'd34;

   // Register indexes
   localparam csr_index_type CSR_FIVE_BIT_GREEN = 3'd0;
   localparam csr_index_type CSR_SWAP_RED_BLUE  = 3'd1;
   localparam csr_index_type CSR_TEXT_COLOR     = 3'd2;
   localparam csr_index_type CSR_BRUSH_COLOR    = 3'd3;
   localparam csr_index_type CSR_BRUSH_SOLID    = 3'd4;
   localparam csr_index_type CSR_PEN_PIXEL      = 3'd5;

   typedef struct packed {
      logic      five_bit_green;
      logic      swap_red_blue;
      color_type text_color;
      color_type brush_color;
      logic      brush_solid;
      pix16_type pen_pixel;
   } cfg_type;

endpackage

`default_nettype wire

// ----- src/rop16_req_if.sv -----
// ----------------------------------------------------------------------------
// rop16_req_if
// Request channel: operation code and the three pixels of one position.
// ----------------------------------------------------------------------------
`default_nettype none

interface rop16_req_if
   import rop16_pkg::*;
();
   logic      valid;
   logic      ready;
   op_type    op;
   pix16_type src_pixel;
   pix16_type dst_pixel;
   pix16_type pat_pixel;

   modport source (output valid, op, src_pixel, dst_pixel, pat_pixel, input ready);
   modport sink   (input valid, op, src_pixel, dst_pixel, pat_pixel, output ready);
   modport monitor (input valid, ready, op, src_pixel, dst_pixel, pat_pixel);
endinterface

`default_nettype wire

// ----- src/rop16_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rop16_rsp_if
// Response channel: the new destination pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rop16_rsp_if
   import rop16_pkg::*;
();
   logic      valid;
   logic      ready;
   pix16_type new_pixel;

   modport source  (output valid, new_pixel, input ready);
   modport sink    (input valid, new_pixel, output ready);
   modport monitor (input valid, ready, new_pixel);
endinterface

`default_nettype wire

// ----- src/rop16_alu.sv -----
// ----------------------------------------------------------------------------
// rop16_alu
// Bitwise raster-operation logic with colour packing for one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rop16_alu
   import rop16_pkg::*;
(
   input  cfg_type   cfg,
   input  op_type    op,
   input  pix16_type src_pixel,
   input  pix16_type dst_pixel,
   input  pix16_type pat_pixel,
   output pix16_type new_pixel
);

   function automatic pix16_type pack_color(input color_type c, input logic g5,
                                            input logic swap);
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] g;
      g  = c[15:8];
      hi = swap ? c[23:16] : c[7:0];
      lo = swap ? c[7:0]   : c[23:16];
      if (g5) begin
         pack_color = {1'b0, hi[7:3], g[7:3], lo[7:3]};
      end else begin
         pack_color = {hi[7:3], g[7:2], lo[7:3]};
      end
   endfunction

   pix16_type text_pix;
   pix16_type brush_pix;
   pix16_type glyph_mask;
   pix16_type s;
   pix16_type d;
   pix16_type p;
   pix16_type q;

   assign s          = src_pixel;
   assign d          = dst_pixel;
   assign p          = pat_pixel;
   assign q          = cfg.pen_pixel;
   assign text_pix   = pack_color(cfg.text_color, cfg.five_bit_green, cfg.swap_red_blue);
   assign brush_pix  = cfg.brush_solid
                     ? pack_color(cfg.brush_color, cfg.five_bit_green, cfg.swap_red_blue)
                     : p;
   // glyph mask: low source byte in both halves
   assign glyph_mask = {src_pixel[BYTE_BITS-1:0], src_pixel[BYTE_BITS-1:0]};

   always_comb begin
      case (op)
         OP_BLACKNESS:      new_pixel = '0;
         OP_WHITENESS:      new_pixel = PIX_MASK;
         OP_SRCCOPY:        new_pixel = s;
         OP_NOTSRCCOPY:     new_pixel = ~s;
         OP_DSTINVERT:      new_pixel = ~d;
         OP_SRCERASE:       new_pixel = s & ~d;
         OP_NOTSRCERASE:    new_pixel = ~s & ~d;
         OP_SRCINVERT:      new_pixel = d ^ s;
         OP_SRCAND:         new_pixel = d & s;
         OP_SRCPAINT:       new_pixel = d | s;
         OP_DSPDXAX:        new_pixel = (glyph_mask & text_pix) | (~glyph_mask & d);
         OP_SPNA:           new_pixel = s & ~p;
         OP_PDXN:           new_pixel = d ^ ~p;
         OP_DSNA:           new_pixel = ~s & d;
         OP_MERGECOPY:      new_pixel = s & p;
         OP_MERGEPAINT:     new_pixel = ~s | d;
         OP_PATCOPY:        new_pixel = brush_pix;
         OP_PATINVERT:      new_pixel = brush_pix ^ d;
         OP_PATPAINT:       new_pixel = d | p | ~s;
         OP_R2_BLACK:       new_pixel = '0;
         OP_R2_NOTMERGEPEN: new_pixel = ~(d | q);
         OP_R2_MASKNOTPEN:  new_pixel = d & ~q;
         OP_R2_NOTCOPYPEN:  new_pixel = ~q;
         OP_R2_MASKPENNOT:  new_pixel = q & ~d;
         OP_R2_NOT:         new_pixel = ~d;
         OP_R2_XORPEN:      new_pixel = d ^ q;
         OP_R2_NOTMASKPEN:  new_pixel = ~(d & q);
         OP_R2_MASKPEN:     new_pixel = d & q;
         OP_R2_NOTXORPEN:   new_pixel = ~(d ^ q);
         OP_R2_NOP:         new_pixel = d;
         OP_R2_MERGENOTPEN: new_pixel = d | ~q;
         OP_R2_COPYPEN:     new_pixel = q;
         OP_R2_MERGEPENNOT: new_pixel = q | ~d;
         OP_R2_MERGEPEN:    new_pixel = d | q;
         OP_R2_WHITE:       new_pixel = PIX_MASK;
         default:           new_pixel = d; // unknown code leaves the pixel alone
      endcase
   end

endmodule

`default_nettype wire

// ----- src/raster_op_pixel_unit_16bpp.sv -----
// ----------------------------------------------------------------------------
// raster_op_pixel_unit_16bpp
// 16bpp blitter raster-operation unit: ROP3 set and the sixteen ROP2 modes.
// ----------------------------------------------------------------------------
//
//   channel    direction  handshake     carries
//   --------   ---------  ------------  ------------------------------------
//   req_chan   in         valid/ready   op, src_pixel, dst_pixel, pat_pixel
//   rsp_chan   out        valid/ready   new_pixel
//   csr_*      in         write enable  register index, write data
//
// One request per clock while rsp_chan does not stall; each request passes
// through the input register, then the result register, to its response.
// The raster logic sits between the two registers and is combinational.
// Reset (synchronous, active high) empties both stages and loads the
// register defaults; brush_solid comes up set.
// A stall on rsp_chan holds the result; the input stage keeps taking
// requests until both stages are full.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_op_pixel_unit_16bpp
   import rop16_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   rop16_req_if.sink          req_chan,
   rop16_rsp_if.source        rsp_chan,
   input  wire logic          csr_we,
   input  wire csr_index_type csr_index,
   input  wire color_type     csr_wdata
);

   // Configuration registers
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Input stage
   logic      s1_valid_ff;
   logic      s1_valid_in;
   op_type    s1_op_ff;
   pix16_type s1_src_ff;
   pix16_type s1_dst_ff;
   pix16_type s1_pat_ff;

   // Result stage
   logic      out_valid_ff;
   logic      out_valid_in;
   pix16_type out_pixel_ff;
   pix16_type out_pixel_in;

   logic out_free;
   logic s1_free;

   // Register writes: keep the low bits of the data only.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FIVE_BIT_GREEN: cfg_in.five_bit_green = csr_wdata[0];
            CSR_SWAP_RED_BLUE:  cfg_in.swap_red_blue  = csr_wdata[0];
            CSR_TEXT_COLOR:     cfg_in.text_color     = csr_wdata;
            CSR_BRUSH_COLOR:    cfg_in.brush_color    = csr_wdata;
            CSR_BRUSH_SOLID:    cfg_in.brush_solid    = csr_wdata[0];
            CSR_PEN_PIXEL:      cfg_in.pen_pixel      = csr_wdata[PIX_W-1:0];
            default:            cfg_in = cfg_ff; // drop writes beyond the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.five_bit_green <= 1'b0;
         cfg_ff.swap_red_blue  <= 1'b0;
         cfg_ff.text_color     <= '0;
         cfg_ff.brush_color    <= '0;
         cfg_ff.brush_solid    <= 1'b1;
         cfg_ff.pen_pixel      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Flow control: the result register frees when empty or taken, the input
   // register frees when empty or when it can pass into the result register.
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign s1_free        = !s1_valid_ff || out_free;
   assign req_chan.ready = s1_free;

   assign s1_valid_in  = s1_free  ? req_chan.valid : s1_valid_ff;
   assign out_valid_in = out_free ? s1_valid_ff    : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the request when the input stage advances.
   always_ff @(posedge clock) begin
      if (s1_free && req_chan.valid) begin
         s1_op_ff  <= req_chan.op;
         s1_src_ff <= req_chan.src_pixel;
         s1_dst_ff <= req_chan.dst_pixel;
         s1_pat_ff <= req_chan.pat_pixel;
      end
   end

   rop16_alu u_alu (
      .cfg       (cfg_ff),
      .op        (s1_op_ff),
      .src_pixel (s1_src_ff),
      .dst_pixel (s1_dst_ff),
      .pat_pixel (s1_pat_ff),
      .new_pixel (out_pixel_in)
   );

   // Hold the result while the response is stalled.
   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         out_pixel_ff <= out_pixel_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.new_pixel = out_pixel_ff;

endmodule

`default_nettype wire

// ----- src/rop16_checker.sv -----
// ----------------------------------------------------------------------------
// rop16_checker
// Port-level checks on the raster-operation unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "raster_op_pixel_unit_16bpp_assert.svh"

module rop16_checker
   import rop16_pkg::*;
(
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      req_ready,
   input wire logic      rsp_valid,
   input wire logic      rsp_ready,
   input wire pix16_type rsp_new_pixel
);

   // Response stays up and steady while stalled.
   `ROP16_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ROP16_ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_new_pixel))
   // Both stages come out of reset empty.
   `ROP16_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && req_ready)
   // Requests are refused only when a stalled response fills the pipe.
   `ROP16_ASSERT_IMPL(a_ready_backpressure, clock, reset, !req_ready, rsp_valid && !rsp_ready)

endmodule

bind raster_op_pixel_unit_16bpp rop16_checker u_rop16_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_new_pixel (rsp_chan.new_pixel)
);

`default_nettype wire

// ----- tb/raster_op_pixel_unit_16bpp_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// raster_op_pixel_unit_16bpp_tb
// Self-checking bench for the 16bpp raster-operation unit. A short table of
// hand-picked requests runs at the reset settings, then random requests run
// under several register settings, the extremes among them. A local model
// of the raster logic predicts each new pixel that the table does not give; a
// monitor checks each response in order, while both channel ends idle and stall at random.
// ----------------------------------------------------------------------------

module raster_op_pixel_unit_16bpp_tb;
   import rop16_pkg::*;

   localparam int HALF_PERIOD      = 2;
   localparam int RESET_CYCLES     = 7;
   // Two pipeline stages; settle time after draining, before touching registers.
   localparam int SETTLE_CYCLES    = 6;
   localparam int PHASES           = 8;
   localparam int ITEMS_PER_PHASE  = 240;
   localparam int HOLD_OFF_CYCLES  = 100;
   localparam int FIRST_HOLD_OFF   = 300;
   localparam int HOLD_OFF_SPACING = 900;
   localparam int CYCLE_LIMIT      = 200000;

   // Codes with no operation behind them: the destination passes through.
   localparam op_type OP_FIRST_UNKNOWN = 6'd35;
   localparam op_type OP_LAST_CODE     = 6'd63;
   // Register indexes past the end of the list: writes must be ignored.
   localparam csr_index_type CSR_INDEX_SPARE_LO = 3'd6;
   localparam csr_index_type CSR_INDEX_SPARE_HI = 3'd7;

   typedef struct packed {
      op_type    op;
      pix16_type src_pixel;
      pix16_type dst_pixel;
      pix16_type pat_pixel;
      logic      golden_known;
      pix16_type golden;
   } stimulus_row_type;

   // Rows with golden_known set carry a result read straight off the
   // operation at reset settings (text colour 0, solid brush of colour 0,
   // pen 0); the rest go through the predictor.
   localparam int DIRECTED_COUNT = 27;
   stimulus_row_type directed_rows [DIRECTED_COUNT] = '{
      '{OP_BLACKNESS,      16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000},
      '{OP_WHITENESS,      16'h0000, 16'h0000, 16'h0000, 1'b1, 16'hFFFF},
      '{OP_SRCCOPY,        16'hFFFF, 16'h0000, 16'h0000, 1'b1, 16'hFFFF},
      '{OP_SRCCOPY,        16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000},
      '{OP_NOTSRCCOPY,     16'h0000, 16'h1234, 16'h5678, 1'b1, 16'hFFFF},
      '{OP_DSTINVERT,      16'hA5A5, 16'hFFFF, 16'h0000, 1'b1, 16'h0000},
      '{OP_SRCERASE,       16'hF0F0, 16'h3C3C, 16'h0000, 1'b0, 16'h0000},
      '{OP_NOTSRCERASE,    16'h0F0F, 16'h3333, 16'hFFFF, 1'b0, 16'h0000},
      '{OP_SRCINVERT,      16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 16'h0000},
      '{OP_SRCAND,         16'hAAAA, 16'hFF00, 16'h5555, 1'b0, 16'h0000},
      '{OP_SRCPAINT,       16'h8001, 16'h0180, 16'h0000, 1'b0, 16'h0000},
      // glyph mask: high byte of the source is ignored
      '{OP_DSPDXAX,        16'hFF00, 16'hBEEF, 16'h1234, 1'b1, 16'hBEEF},
      '{OP_DSPDXAX,        16'h00FF, 16'hBEEF, 16'h1234, 1'b1, 16'h0000},
      '{OP_SPNA,           16'hFFFF, 16'h0000, 16'h0F0F, 1'b0, 16'h0000},
      '{OP_PDXN,           16'h1357, 16'h9BDF, 16'hFFFF, 1'b0, 16'h0000},
      '{OP_DSNA,           16'hCCCC, 16'hFFFF, 16'h0000, 1'b0, 16'h0000},
      '{OP_MERGECOPY,      16'hFFFF, 16'h0000, 16'hA5A5, 1'b0, 16'h0000},
      '{OP_MERGEPAINT,     16'h00FF, 16'h0F00, 16'h0000, 1'b0, 16'h0000},
      // solid brush of colour 0 stands in for the pattern
      '{OP_PATCOPY,        16'h1111, 16'h2222, 16'hFFFF, 1'b1, 16'h0000},
      '{OP_PATINVERT,      16'h0000, 16'hC3C3, 16'hFFFF, 1'b1, 16'hC3C3},
      '{OP_PATPAINT,       16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000},
      '{OP_R2_BLACK,       16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000},
      '{OP_R2_NOT,         16'h0000, 16'hFFFF, 16'h0000, 1'b1, 16'h0000},
      '{OP_R2_COPYPEN,     16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000},
      '{OP_R2_WHITE,       16'h0000, 16'h0000, 16'h0000, 1'b1, 16'hFFFF},
      // unknown codes leave the destination alone
      '{OP_FIRST_UNKNOWN,  16'hFFFF, 16'h1357, 16'hFFFF, 1'b1, 16'h1357},
      '{OP_LAST_CODE,      16'h0000, 16'hFFFF, 16'h0000, 1'b1, 16'hFFFF}
   };

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   color_type     csr_wdata;

   rop16_req_if req_chan ();
   rop16_rsp_if rsp_chan ();

   raster_op_pixel_unit_16bpp i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the unit's registers, updated as each write lands.
   cfg_type     unit_cfg;
   // New pixels still owed by the unit, oldest first.
   pix16_type   pending_pixels [$];
   int unsigned error_count       = 0;
   int unsigned accepted_requests = 0;
   int unsigned cycle_count       = 0;
   // Hand-typed result for the request on offer, if the table gives one.
   logic        offer_golden_known;
   pix16_type   offer_golden;

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Raster logic as the bench understands it
   // ------------------------------------------------------------------------

   // Pack a 0x00BBGGRR colour to 565 or 555, red and blue swapped on request.
   function automatic pix16_type pack_color16(color_type c);
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] g;
      g  = c[15:8];
      hi = unit_cfg.swap_red_blue ? c[23:16] : c[7:0];
      lo = unit_cfg.swap_red_blue ? c[7:0]   : c[23:16];
      if (unit_cfg.five_bit_green) begin
         return {1'b0, hi[7:3], g[7:3], lo[7:3]};
      end
      return {hi[7:3], g[7:2], lo[7:3]};
   endfunction

   function automatic pix16_type predict_new_pixel(op_type op, pix16_type s,
                                                   pix16_type d, pix16_type p);
      pix16_type brush;
      pix16_type glyph_mask;
      pix16_type pen;
      brush      = unit_cfg.brush_solid ? pack_color16(unit_cfg.brush_color) : p;
      glyph_mask = {s[7:0], s[7:0]};
      pen        = unit_cfg.pen_pixel;
      case (op)
         OP_BLACKNESS:      return '0;
         OP_WHITENESS:      return PIX_MASK;
         OP_SRCCOPY:        return s;
         OP_NOTSRCCOPY:     return ~s;
         OP_DSTINVERT:      return ~d;
         OP_SRCERASE:       return s & ~d;
         OP_NOTSRCERASE:    return ~s & ~d;
         OP_SRCINVERT:      return d ^ s;
         OP_SRCAND:         return d & s;
         OP_SRCPAINT:       return d | s;
         OP_DSPDXAX: begin
            return (glyph_mask & pack_color16(unit_cfg.text_color)) | (~glyph_mask & d);
         end
         OP_SPNA:           return s & ~p;
         OP_PDXN:           return d ^ ~p;
         OP_DSNA:           return ~s & d;
         OP_MERGECOPY:      return s & p;
         OP_MERGEPAINT:     return ~s | d;
         OP_PATCOPY:        return brush;
         OP_PATINVERT:      return brush ^ d;
         OP_PATPAINT:       return d | p | ~s;
         OP_R2_BLACK:       return '0;
         OP_R2_NOTMERGEPEN: return ~(d | pen);
         OP_R2_MASKNOTPEN:  return d & ~pen;
         OP_R2_NOTCOPYPEN:  return ~pen;
         OP_R2_MASKPENNOT:  return pen & ~d;
         OP_R2_NOT:         return ~d;
         OP_R2_XORPEN:      return d ^ pen;
         OP_R2_NOTMASKPEN:  return ~(d & pen);
         OP_R2_MASKPEN:     return d & pen;
         OP_R2_NOTXORPEN:   return ~(d ^ pen);
         OP_R2_NOP:         return d;
         OP_R2_MERGENOTPEN: return d | ~pen;
         OP_R2_COPYPEN:     return pen;
         OP_R2_MERGEPENNOT: return pen | ~d;
         OP_R2_MERGEPEN:    return d | pen;
         OP_R2_WHITE:       return PIX_MASK;
         default:           return d;
      endcase
   endfunction

   // Mostly random pixels, with the all-zero and all-one extremes mixed in.
   function automatic pix16_type random_pixel();
      case ($urandom_range(7, 0))
         0:       return '0;
         1:       return PIX_MASK;
         default: return pix16_type'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: expect a pixel for every accepted request, check every response
   // ------------------------------------------------------------------------
   // Both handshakes are looked at in one process, so a request and a
   // response on the same edge are always handled in the same order.
   always @(posedge clock) begin
      pix16_type expected;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            if (offer_golden_known) begin
               pending_pixels.push_back(offer_golden);
            end else begin
               pending_pixels.push_back(predict_new_pixel(req_chan.op, req_chan.src_pixel,
                                                          req_chan.dst_pixel,
                                                          req_chan.pat_pixel));
            end
            accepted_requests++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_pixels.size() == 0) begin
               $error("new_pixel: response %h with no request outstanding",
                      rsp_chan.new_pixel);
               error_count++;
            end else begin
               expected = pending_pixels.pop_front();
               if (rsp_chan.new_pixel !== expected) begin
                  $error("new_pixel: expected %h, actual %h", expected, rsp_chan.new_pixel);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("raster_op_pixel_unit_16bpp_tb: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Response side: stall on a pattern of its own
   // ------------------------------------------------------------------------
   // Stretches of random length: fully ready, randomly stalling, or dropping
   // ready on a regular pattern. Twice in the run, once enough requests have
   // gone in, hold ready low for a long stretch so that both stages fill and
   // the unit pushes back on its request side.
   initial begin : response_sink
      int unsigned mode;
      int unsigned span;
      int unsigned stall_period;
      int unsigned tick;
      int unsigned hold_off_mark;
      rsp_chan.ready = 1'b0;
      hold_off_mark  = FIRST_HOLD_OFF;
      forever begin
         mode         = $urandom_range(2, 0);
         span         = $urandom_range(200, 20);
         stall_period = $urandom_range(5, 2);
         for (tick = 0; tick < span; tick++) begin
            @(negedge clock);
            if (accepted_requests >= hold_off_mark) begin
               hold_off_mark += HOLD_OFF_SPACING;
               rsp_chan.ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(negedge clock);
            end else begin
               case (mode)
                  0:       rsp_chan.ready <= 1'b1;
                  1:       rsp_chan.ready <= ($urandom_range(99, 0) < 60);
                  default: rsp_chan.ready <= ((tick % stall_period) != 0);
               endcase
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side and register writes
   // ------------------------------------------------------------------------

   // Offer one request from the next falling edge and hold it until taken.
   task automatic offer_request(op_type op, pix16_type s, pix16_type d, pix16_type p,
                                logic golden_known, pix16_type golden);
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.op        <= op;
      req_chan.src_pixel <= s;
      req_chan.dst_pixel <= d;
      req_chan.pat_pixel <= p;
      offer_golden_known <= golden_known;
      offer_golden       <= golden;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid for a number of cycles.
   task automatic pause_requests(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
   endtask

   // Wait for every owed pixel, then let the pipeline settle.
   task automatic wait_drained();
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Drive one write and update the local register copy as it lands.
   task automatic write_register(csr_index_type idx, color_type value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_FIVE_BIT_GREEN: unit_cfg.five_bit_green = value[0];
         CSR_SWAP_RED_BLUE:  unit_cfg.swap_red_blue  = value[0];
         CSR_TEXT_COLOR:     unit_cfg.text_color     = value;
         CSR_BRUSH_COLOR:    unit_cfg.brush_color    = value;
         CSR_BRUSH_SOLID:    unit_cfg.brush_solid    = value[0];
         CSR_PEN_PIXEL:      unit_cfg.pen_pixel      = value[15:0];
         default: ;
      endcase
   endtask

   // Load a whole setting once the unit is idle. Junk goes in the unused
   // upper bits of the narrow writes, and the two spare indexes get a write
   // too, so that truncation and ignored indexes are both exercised.
   task automatic apply_settings(cfg_type want);
      color_type junk;
      wait_drained();
      junk = color_type'($urandom);
      write_register(CSR_FIVE_BIT_GREEN, {junk[23:1], want.five_bit_green});
      junk = color_type'($urandom);
      write_register(CSR_SWAP_RED_BLUE, {junk[23:1], want.swap_red_blue});
      write_register(CSR_TEXT_COLOR, want.text_color);
      write_register(CSR_BRUSH_COLOR, want.brush_color);
      junk = color_type'($urandom);
      write_register(CSR_BRUSH_SOLID, {junk[23:1], want.brush_solid});
      junk = color_type'($urandom);
      write_register(CSR_PEN_PIXEL, {junk[7:0], want.pen_pixel});
      write_register(CSR_INDEX_SPARE_LO, color_type'($urandom));
      write_register(CSR_INDEX_SPARE_HI, color_type'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      cfg_type     want;
      int unsigned items_left;
      int unsigned burst;
      op_type      op;

      // Every input known from time zero; reset high.
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_chan.valid     = 1'b0;
      req_chan.op        = '0;
      req_chan.src_pixel = '0;
      req_chan.dst_pixel = '0;
      req_chan.pat_pixel = '0;
      offer_golden_known = 1'b0;
      offer_golden       = '0;

      unit_cfg                = '0;
      unit_cfg.brush_solid    = 1'b1;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Hand-picked table at the reset settings, back to back.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         offer_request(directed_rows[i].op, directed_rows[i].src_pixel,
                       directed_rows[i].dst_pixel, directed_rows[i].pat_pixel,
                       directed_rows[i].golden_known, directed_rows[i].golden);
      end
      pause_requests(1);

      for (int phase = 0; phase < PHASES; phase++) begin
         // First the all-low setting, then the all-high one, then random.
         case (phase)
            0: want = '0;
            1: begin
               want                = '0;
               want.five_bit_green = 1'b1;
               want.swap_red_blue  = 1'b1;
               want.text_color     = '1;
               want.brush_color    = '1;
               want.brush_solid    = 1'b1;
               want.pen_pixel      = '1;
            end
            default: begin
               want.five_bit_green = $urandom_range(1, 0);
               want.swap_red_blue  = $urandom_range(1, 0);
               want.text_color     = color_type'($urandom);
               want.brush_color    = color_type'($urandom);
               want.brush_solid    = $urandom_range(1, 0);
               want.pen_pixel      = pix16_type'($urandom);
            end
         endcase
         apply_settings(want);

         // Random requests in bursts, with gaps between most of them.
         items_left = ITEMS_PER_PHASE;
         while (items_left > 0) begin
            burst = $urandom_range(48, 1);
            if (burst > items_left) begin
               burst = items_left;
            end
            repeat (burst) begin
               if ($urandom_range(9, 0) == 0) begin
                  op = op_type'($urandom_range(OP_LAST_CODE, OP_FIRST_UNKNOWN));
               end else begin
                  op = op_type'($urandom_range(OP_R2_WHITE, OP_BLACKNESS));
               end
               offer_request(op, random_pixel(), random_pixel(), random_pixel(),
                             1'b0, '0);
            end
            items_left -= burst;
            if ($urandom_range(3, 0) != 0) begin
               pause_requests($urandom_range(6, 1));
            end
         end
         pause_requests(1);
      end

      // Drain, then report.
      wait_drained();
      if (error_count == 0) begin
         $display("raster_op_pixel_unit_16bpp_tb: clean");
      end else begin
         $display("raster_op_pixel_unit_16bpp_tb: errors");
      end
      $finish;
   end

endmodule

// ----- raster_op_pixel_unit_16bpp.f -----
+incdir+src
src/rop16_pkg.sv
src/rop16_req_if.sv
src/rop16_rsp_if.sv
src/rop16_alu.sv
src/raster_op_pixel_unit_16bpp.sv
src/rop16_checker.sv
tb/raster_op_pixel_unit_16bpp_tb.sv
